[rtl/lts_pkg.sv]
// ----------------------------------------------------------------------------
// lts_pkg
// Shared widths, command codes, register indexes and constants of the
// lottery ticket scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package lts_pkg;

  localparam int CMD_W      = 2;
  localparam int IDX_W      = 4;
  localparam int PRIO_W     = 16;
  localparam int RND_W      = 16;
  localparam int TUP_W      = 16;
  localparam int TKT_W      = 11;
  localparam int WIN_W      = 4;
  localparam int CNT_W      = 5;
  localparam int CYC_W      = 16;
  localparam int ACC_W      = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int QUO_W      = 7;
  localparam int DCNT_W     = 3;
  localparam int DIVD_W     = PRIO_W + QUO_W;
  localparam int PROD_W     = TKT_W + RND_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_PRIO = 2'd0,
    CMD_REBUILD    = 2'd1,
    CMD_DRAW       = 2'd2,
    CMD_REPORT     = 2'd3
  } cmd_e;

  localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_COUNT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REBUILD_PERIOD = 1'd1;

  localparam logic [CNT_W-1:0]  CLIENT_COUNT_RESET   = 5'd1;
  localparam logic [CYC_W-1:0]  REBUILD_PERIOD_RESET = 16'd50;
  localparam logic [QUO_W-1:0]  TICKETS_PER_MAX      = 7'd100;
  localparam logic [TKT_W-1:0]  TICKET_LIMIT         = 11'd2047;
  localparam logic [DCNT_W-1:0] QUO_MSB              = 3'd6;

endpackage

`default_nettype wire

[rtl/lts_if.sv]
// ----------------------------------------------------------------------------
// lts_in_if / lts_out_if
// Valid/ready channels for command transactions and result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface lts_in_if
  import lts_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [IDX_W-1:0]  client_index;
  logic [PRIO_W-1:0] priority_value;
  logic [RND_W-1:0]  random_value;
  logic [TUP_W-1:0]  tuple_count;

  modport source (
    output valid, command, client_index, priority_value, random_value, tuple_count,
    input  ready
  );
  modport sink (
    input  valid, command, client_index, priority_value, random_value, tuple_count,
    output ready
  );
endinterface

interface lts_out_if
  import lts_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             status;
  logic [WIN_W-1:0] winner;
  logic [TKT_W-1:0] drawn_ticket;
  logic             rebuilt;
  logic [TKT_W-1:0] total_tickets;

  modport source (
    output valid, status, winner, drawn_ticket, rebuilt, total_tickets,
    input  ready
  );
  modport sink (
    input  valid, status, winner, drawn_ticket, rebuilt, total_tickets,
    output ready
  );
endinterface

`default_nettype wire

[rtl/lts_ram.sv]
// ----------------------------------------------------------------------------
// lts_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/lottery_ticket_scheduler.sv]
// a draw reads the total ticket count, scales the random value to a ticket and finds the
//   winner by a binary search of at most ceil(log2 n) probes, one ticket memory read each
// rebuild: a scan for the top priority over the n active clients, then per active
//   client a multiply, the 7-step quotient divider and a ticket write, inactive entries cleared;
// one transaction in flight; the next is taken while the result waits in the output register
// reset: tables read as zero via per-entry valid flags, client count 1, period 50, tuples 0
// ----------------------------------------------------------------------------
// lottery_ticket_scheduler
// Lottery scheduler: priority table and cumulative ticket table in RAM, a
// sequencer that rebuilds tickets, draws winners by binary search and counts
// reported tuples.
// ----------------------------------------------------------------------------
`default_nettype none

module lottery_ticket_scheduler
  import lts_pkg::*;
#(
  parameter int MAX_CLIENTS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  lts_in_if.sink                in_i,
  lts_out_if.source             out_o
);

  localparam int IW = $clog2(MAX_CLIENTS);
  localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_CLIENTS - 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_MAX_SCAN = 4'd2;
  localparam logic [3:0] S_BLD_MUL  = 4'd3;
  localparam logic [3:0] S_BLD_DIV  = 4'd4;
  localparam logic [3:0] S_BLD_WR   = 4'd5;
  localparam logic [3:0] S_TOT      = 4'd6;
  localparam logic [3:0] S_TKT      = 4'd7;
  localparam logic [3:0] S_SRCH     = 4'd8;
  localparam logic [3:0] S_FIN_RD   = 4'd9;
  localparam logic [3:0] S_FIN      = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0]        state_q, state_d;
  logic [IW-1:0]     ptr_q, ptr_d;
  cmd_e              cmd_q, cmd_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic [RND_W-1:0]  rnd_q, rnd_d;
  logic [TUP_W-1:0]  tup_q, tup_d;
  logic [CNT_W-1:0]  client_count_q;
  logic [CYC_W-1:0]  rebuild_period_q;
  logic [ACC_W-1:0]  tuples_q, tuples_d;
  logic [PRIO_W-1:0] top_q, top_d;
  logic [TKT_W-1:0]  run_q, run_d;
  logic [DIVD_W-1:0] rem_q, rem_d;
  logic [DIVD_W-1:0] dvs_q, dvs_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [DCNT_W-1:0] bit_q, bit_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [IW-1:0]     lo_q, lo_d;
  logic [IW-1:0]     hi_q, hi_d;
  logic [TKT_W-1:0]  ticket_q, ticket_d;
  logic [WIN_W-1:0]  winner_q, winner_d;
  logic              status_q, status_d;
  logic              rebuilt_q, rebuilt_d;
  logic [TKT_W-1:0]  total_q, total_d;

  logic              out_valid_q, out_valid_d;
  logic              out_status_q;
  logic [WIN_W-1:0]  out_winner_q;
  logic [TKT_W-1:0]  out_ticket_q;
  logic              out_rebuilt_q;
  logic [TKT_W-1:0]  out_total_q;
  logic              out_load;

  logic [MAX_CLIENTS-1:0] p_vld_q, p_vld_d;
  logic [MAX_CLIENTS-1:0] c_vld_q, c_vld_d;
  logic                   p_rvld_q, c_rvld_q;

  logic              p_we;
  logic [IW-1:0]     p_waddr;
  logic [PRIO_W-1:0] p_rdata, p_rd;
  logic              c_we;
  logic [TKT_W-1:0]  c_wdata;
  logic [TKT_W-1:0]  c_rdata, c_rd;

  logic [IW-1:0]     last_idx;
  logic [ACC_W-1:0]  tup_sum;
  logic [TKT_W:0]    run_sum;
  logic [TKT_W-1:0]  run_sat;
  logic [IW-1:0]     lo_n, hi_n;
  logic [IW:0]       mid_sum;
  logic              div_ge;

  lts_ram #(
    .WIDTH (PRIO_W),
    .DEPTH (MAX_CLIENTS)
  ) u_prio_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (prio_q),
    .raddr_i (ptr_d),
    .rdata_o (p_rdata)
  );

  lts_ram #(
    .WIDTH (TKT_W),
    .DEPTH (MAX_CLIENTS)
  ) u_ticket_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (ptr_q),
    .wdata_i (c_wdata),
    .raddr_i (ptr_d),
    .rdata_o (c_rdata)
  );

  // never-written entries read as zero
  assign p_rd = p_rvld_q ? p_rdata : '0;
  assign c_rd = c_rvld_q ? c_rdata : '0;

  always_comb begin
    if (client_count_q == '0) begin
      last_idx = '0;
    end else if (int'(client_count_q) > MAX_CLIENTS) begin
      last_idx = LAST_SLOT;
    end else begin
      last_idx = IW'(client_count_q - CNT_W'(1));
    end
  end

  assign tup_sum = tuples_q + ACC_W'(tup_q);
  assign run_sum = {1'b0, run_q} + (TKT_W + 1)'(quo_q);
  assign run_sat = (run_sum > {1'b0, TICKET_LIMIT}) ? TICKET_LIMIT : run_sum[TKT_W-1:0];
  assign div_ge  = (rem_q >= dvs_q);
  assign p_waddr = IW'(idx_q);

  // binary search bounds for the next probe
  always_comb begin
    if (state_q == S_SRCH) begin
      if (c_rd >= ticket_q) begin
        lo_n = lo_q;
        hi_n = ptr_q;
      end else begin
        lo_n = ptr_q + IW'(1);
        hi_n = hi_q;
      end
    end else begin
      lo_n = '0;
      hi_n = last_idx;
    end
    mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
  end

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    prio_d    = prio_q;
    rnd_d     = rnd_q;
    tup_d     = tup_q;
    tuples_d  = tuples_q;
    top_d     = top_q;
    run_d     = run_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    quo_d     = quo_q;
    bit_d     = bit_q;
    prod_d    = prod_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    ticket_d  = ticket_q;
    winner_d  = winner_q;
    status_d  = status_q;
    rebuilt_d = rebuilt_q;
    total_d   = total_q;
    p_we      = 1'b0;
    c_we      = 1'b0;
    c_wdata   = '0;
    out_load  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cmd_d     = cmd_e'(in_i.command);
          idx_d     = in_i.client_index;
          prio_d    = in_i.priority_value;
          rnd_d     = in_i.random_value;
          tup_d     = in_i.tuple_count;
          status_d  = 1'b0;
          rebuilt_d = 1'b0;
          winner_d  = '0;
          ticket_d  = '0;
          state_d   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (cmd_q)
          CMD_WRITE_PRIO: begin
            p_we    = (int'(idx_q) < MAX_CLIENTS);
            state_d = S_FIN_RD;
          end
          CMD_REBUILD: begin
            ptr_d   = '0;
            top_d   = '0;
            state_d = S_MAX_SCAN;
          end
          CMD_DRAW: begin
            ptr_d   = last_idx;
            state_d = S_TOT;
          end
          CMD_REPORT: begin
            if (tup_sum >= ACC_W'(rebuild_period_q)) begin
              tuples_d = '0;
              ptr_d    = '0;
              top_d    = '0;
              state_d  = S_MAX_SCAN;
            end else begin
              tuples_d = tup_sum;
              state_d  = S_FIN_RD;
            end
          end
          default: begin
            state_d = S_FIN_RD;
          end
        endcase
      end
      S_MAX_SCAN: begin
        if (p_rd > top_q) begin
          top_d = p_rd;
        end
        if (ptr_q == last_idx) begin
          if (top_d == '0) begin
            status_d = 1'b1;
            state_d  = S_FIN_RD;
          end else begin
            ptr_d   = '0;
            run_d   = '0;
            state_d = S_BLD_MUL;
          end
        end else begin
          ptr_d = ptr_q + IW'(1);
        end
      end
      S_BLD_MUL: begin
        if (ptr_q <= last_idx) begin
          rem_d   = DIVD_W'(p_rd) * DIVD_W'(TICKETS_PER_MAX);
          dvs_d   = DIVD_W'(top_q) << (QUO_W - 1);
          quo_d   = '0;
          bit_d   = QUO_MSB;
          state_d = S_BLD_DIV;
        end else begin
          // inactive entries are cleared
          c_we = 1'b1;
          if (ptr_q == LAST_SLOT) begin
            rebuilt_d = 1'b1;
            state_d   = S_FIN_RD;
          end else begin
            ptr_d = ptr_q + IW'(1);
          end
        end
      end
      S_BLD_DIV: begin
        if (div_ge) begin
          rem_d = rem_q - dvs_q;
        end
        quo_d = {quo_q[QUO_W-2:0], div_ge};
        dvs_d = dvs_q >> 1;
        if (bit_q == '0) begin
          state_d = S_BLD_WR;
        end else begin
          bit_d = bit_q - DCNT_W'(1);
        end
      end
      S_BLD_WR: begin
        c_we    = 1'b1;
        c_wdata = run_sat;
        run_d   = run_sat;
        if (ptr_q == LAST_SLOT) begin
          rebuilt_d = 1'b1;
          state_d   = S_FIN_RD;
        end else begin
          ptr_d   = ptr_q + IW'(1);
          state_d = S_BLD_MUL;
        end
      end
      S_TOT: begin
        if (c_rd == '0) begin
          status_d = 1'b1;
          state_d  = S_FIN_RD;
        end else begin
          prod_d  = PROD_W'(c_rd) * PROD_W'(rnd_q);
          state_d = S_TKT;
        end
      end
      S_TKT: begin
        ticket_d = TKT_W'(prod_q >> RND_W) + TKT_W'(1);
        lo_d     = lo_n;
        hi_d     = hi_n;
        if (lo_n == hi_n) begin
          winner_d = WIN_W'(lo_n);
          state_d  = S_FIN_RD;
        end else begin
          ptr_d   = mid_sum[IW:1];
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n == hi_n) begin
          winner_d = WIN_W'(lo_n);
          state_d  = S_FIN_RD;
        end else begin
          ptr_d = mid_sum[IW:1];
        end
      end
      S_FIN_RD: begin
        ptr_d   = last_idx;
        state_d = S_FIN;
      end
      S_FIN: begin
        total_d = c_rd;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    p_vld_d = p_vld_q;
    c_vld_d = c_vld_q;
    if (p_we) begin
      p_vld_d[p_waddr] = 1'b1;
    end
    if (c_we) begin
      c_vld_d[ptr_q] = 1'b1;
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      ptr_q            <= '0;
      client_count_q   <= CLIENT_COUNT_RESET;
      rebuild_period_q <= REBUILD_PERIOD_RESET;
      tuples_q         <= '0;
      out_valid_q      <= 1'b0;
      p_vld_q          <= '0;
      c_vld_q          <= '0;
      p_rvld_q         <= 1'b0;
      c_rvld_q         <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      tuples_q    <= tuples_d;
      out_valid_q <= out_valid_d;
      p_vld_q     <= p_vld_d;
      c_vld_q     <= c_vld_d;
      p_rvld_q    <= p_vld_q[ptr_d];
      c_rvld_q    <= c_vld_q[ptr_d];
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CLIENT_COUNT:   client_count_q   <= cfg_data_i[CNT_W-1:0];
          CFG_REBUILD_PERIOD: rebuild_period_q <= cfg_data_i[CYC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    idx_q     <= idx_d;
    prio_q    <= prio_d;
    rnd_q     <= rnd_d;
    tup_q     <= tup_d;
    top_q     <= top_d;
    run_q     <= run_d;
    rem_q     <= rem_d;
    dvs_q     <= dvs_d;
    quo_q     <= quo_d;
    bit_q     <= bit_d;
    prod_q    <= prod_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    ticket_q  <= ticket_d;
    winner_q  <= winner_d;
    status_q  <= status_d;
    rebuilt_q <= rebuilt_d;
    total_q   <= total_d;
    if (out_load) begin
      out_status_q  <= status_q;
      out_winner_q  <= winner_q;
      out_ticket_q  <= ticket_q;
      out_rebuilt_q <= rebuilt_q;
      out_total_q   <= total_q;
    end
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.winner        = out_winner_q;
  assign out_o.drawn_ticket  = out_ticket_q;
  assign out_o.rebuilt       = out_rebuilt_q;
  assign out_o.total_tickets = out_total_q;

`ifndef NO_ASSERTIONS
  a_accept_dispatch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == S_DISPATCH)
    else $error("accepted transaction not dispatched");

  a_search_bounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SRCH |-> lo_q < hi_q && ptr_q >= lo_q && ptr_q < hi_q)
    else $error("search probe outside bounds");

  a_quotient_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BLD_WR |-> quo_q <= TICKETS_PER_MAX)
    else $error("ticket quotient above limit");

  a_build_top : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BLD_MUL || state_q == S_BLD_DIV |-> top_q != '0)
    else $error("rebuild with zero maximum priority");

  a_draw_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.drawn_ticket != '0 |-> !out_o.status && !out_o.rebuilt)
    else $error("drawn ticket with error or rebuild");
`endif

endmodule

`default_nettype wire

[tb/sv/lottery_ticket_scheduler_tb.sv]
// ----------------------------------------------------------------------------
// lottery_ticket_scheduler_tb
// Self-checking bench for the lottery ticket scheduler. A directed table
// covers empty tables, stale tables, extreme priorities, tickets and tuple
// counts, and the client count and cycle length at their edges. Random
// phases follow under changing register settings with random idling on both
// channels. Each result is checked field by field against its typed row or
// an in-bench model of the priority table, ticket table and tuple counter.
// ----------------------------------------------------------------------------
`default_nettype none

module lottery_ticket_scheduler_tb;
  import lts_pkg::*;

  localparam int CLIENTS         = 16;
  localparam int DIR_ROWS        = 27;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int TAIL_CYCLES     = 200;
  localparam int CYCLE_LIMIT     = 1000000;

  typedef struct packed {
    cmd_e              command;
    logic [IDX_W-1:0]  client_index;
    logic [PRIO_W-1:0] priority_value;
    logic [RND_W-1:0]  random_value;
    logic [TUP_W-1:0]  tuple_count;
  } sched_cmd_t;

  typedef struct packed {
    logic             status;
    logic [WIN_W-1:0] winner;
    logic [TKT_W-1:0] drawn_ticket;
    logic             rebuilt;
    logic [TKT_W-1:0] total_tickets;
  } sched_result_t;

  typedef struct packed {
    logic          set_cfg;
    logic [CNT_W-1:0] clients;
    logic [CYC_W-1:0] cycle_len;
    sched_cmd_t    cmd;
    logic          typed;
    sched_result_t res;
  } dir_row_t;

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // empty tables after reset
    '{1'b0, 5'd0, 16'd0, '{CMD_DRAW, 4'd0, 16'h0000, 16'hFFFF, 16'h0000},
      1'b1, '{1'b1, 4'd0, 11'd0, 1'b0, 11'd0}},
    '{1'b0, 5'd0, 16'd0, '{CMD_REBUILD, 4'd0, 16'h0000, 16'h0000, 16'h0000},
      1'b1, '{1'b1, 4'd0, 11'd0, 1'b0, 11'd0}},
    '{1'b0, 5'd0, 16'd0, '{CMD_REPORT, 4'd0, 16'h0000, 16'h0000, 16'h0000},
      1'b1, '{1'b0, 4'd0, 11'd0, 1'b0, 11'd0}},
    '{1'b0, 5'd0, 16'd0, '{CMD_WRITE_PRIO, 4'd15, 16'hFFFF, 16'h0000, 16'h0000},
      1'b1, '{1'b0, 4'd0, 11'd0, 1'b0, 11'd0}},
    '{1'b0, 5'd0, 16'd0, '{CMD_WRITE_PRIO, 4'd0, 16'hFFFF, 16'h0000, 16'h0000},
      1'b1, '{1'b0, 4'd0, 11'd0, 1'b0, 11'd0}},
    '{1'b0, 5'd0, 16'd0, '{CMD_REBUILD, 4'd0, 16'h0000, 16'h0000, 16'h0000},
      1'b1, '{1'b0, 4'd0, 11'd0, 1'b1, 11'd100}},
    '{1'b0, 5'd0, 16'd0, '{CMD_DRAW, 4'd0, 16'h0000, 16'h0000, 16'h0000},
      1'b1, '{1'b0, 4'd0, 11'd1, 1'b0, 11'd100}},
    '{1'b0, 5'd0, 16'd0, '{CMD_DRAW, 4'd0, 16'h0000, 16'hFFFF, 16'h0000},
      1'b1, '{1'b0, 4'd0, 11'd100, 1'b0, 11'd100}},
    '{1'b0, 5'd0, 16'd0, '{CMD_REPORT, 4'd0, 16'h0000, 16'h0000, 16'hFFFF},
      1'b1, '{1'b0, 4'd0, 11'd0, 1'b1, 11'd100}},
    // all clients active on a stale table, zero cycle length
    '{1'b1, 5'd16, 16'd0, '{CMD_DRAW, 4'd0, 16'h0000, 16'h1234, 16'h0000},
      1'b1, '{1'b1, 4'd0, 11'd0, 1'b0, 11'd0}},
    '{1'b0, 5'd0, 16'd0, '{CMD_REPORT, 4'd0, 16'h0000, 16'h0000, 16'h0000},
      1'b1, '{1'b0, 4'd0, 11'd0, 1'b1, 11'd200}},
    '{1'b0, 5'd0, 16'd0, '{CMD_WRITE_PRIO, 4'd7, 16'h0001, 16'h0000, 16'h0000},
      1'b0, '0},
    '{1'b0, 5'd0, 16'd0, '{CMD_REBUILD, 4'd0, 16'h0000, 16'h0000, 16'h0000},
      1'b0, '0},
    '{1'b0, 5'd0, 16'd0, '{CMD_DRAW, 4'd0, 16'h0000, 16'h8000, 16'h0000},
      1'b0, '0},
    '{1'b0, 5'd0, 16'd0, '{CMD_DRAW, 4'd0, 16'h0000, 16'h0000, 16'h0000},
      1'b0, '0},
    '{1'b0, 5'd0, 16'd0, '{CMD_DRAW, 4'd0, 16'h0000, 16'hFFFF, 16'h0000},
      1'b0, '0},
    // client count zero, longest cycle
    '{1'b1, 5'd0, 16'hFFFF, '{CMD_DRAW, 4'd0, 16'h0000, 16'hC000, 16'h0000},
      1'b0, '0},
    '{1'b0, 5'd0, 16'd0, '{CMD_REPORT, 4'd0, 16'h0000, 16'h0000, 16'hFFFF},
      1'b0, '0},
    // client count above range, all priorities zero
    '{1'b1, 5'd31, 16'd1, '{CMD_WRITE_PRIO, 4'd0, 16'h0000, 16'h0000, 16'h0000},
      1'b0, '0},
    '{1'b0, 5'd0, 16'd0, '{CMD_WRITE_PRIO, 4'd15, 16'h0000, 16'h0000, 16'h0000},
      1'b0, '0},
    '{1'b0, 5'd0, 16'd0, '{CMD_WRITE_PRIO, 4'd7, 16'h0000, 16'h0000, 16'h0000},
      1'b0, '0},
    '{1'b0, 5'd0, 16'd0, '{CMD_REPORT, 4'd0, 16'h0000, 16'h0000, 16'h0001},
      1'b0, '0},
    '{1'b0, 5'd0, 16'd0, '{CMD_REBUILD, 4'd0, 16'h0000, 16'h0000, 16'h0000},
      1'b0, '0},
    '{1'b0, 5'd0, 16'd0, '{CMD_WRITE_PRIO, 4'd3, 16'h00AA, 16'h0000, 16'h0000},
      1'b0, '0},
    '{1'b0, 5'd0, 16'd0, '{CMD_WRITE_PRIO, 4'd9, 16'h5555, 16'h0000, 16'h0000},
      1'b0, '0},
    '{1'b0, 5'd0, 16'd0, '{CMD_REBUILD, 4'd0, 16'h0000, 16'h0000, 16'h0000},
      1'b0, '0},
    '{1'b0, 5'd0, 16'd0, '{CMD_DRAW, 4'd0, 16'h0000, 16'h5A5A, 16'h0000},
      1'b0, '0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  lts_in_if  cmd_if ();
  lts_out_if res_if ();

  lottery_ticket_scheduler #(
    .MAX_CLIENTS (CLIENTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (cmd_if),
    .out_o      (res_if)
  );

  // model state
  logic [PRIO_W-1:0] prio_tbl [CLIENTS];
  logic [TKT_W-1:0]  cum_tbl  [CLIENTS];
  logic [ACC_W-1:0]  tuple_acc;
  logic [CNT_W-1:0]  cfg_clients;
  logic [CYC_W-1:0]  cfg_cycle;

  sched_result_t awaited_results [$];
  sched_result_t oldest;

  int  errors;
  int  cycle_count;
  int  sent_count;
  int  settings_count;
  int  won_draws;
  int  rebuild_results;
  bit  calm;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic int active_clients();
    int n;
    n = int'(cfg_clients);
    if (n == 0) n = 1;
    if (n > CLIENTS) n = CLIENTS;
    return n;
  endfunction

  function automatic bit rebuild_tickets();
    int n;
    int top;
    int run;
    n   = active_clients();
    top = 0;
    run = 0;
    for (int i = 0; i < n; i++) begin
      if (int'(prio_tbl[i]) > top) top = int'(prio_tbl[i]);
    end
    if (top == 0) return 1'b0;
    for (int i = 0; i < CLIENTS; i++) begin
      if (i < n) begin
        run += (int'(prio_tbl[i]) * int'(TICKETS_PER_MAX)) / top;
        if (run > int'(TICKET_LIMIT)) run = int'(TICKET_LIMIT);
        cum_tbl[i] = run[TKT_W-1:0];
      end else begin
        cum_tbl[i] = '0;
      end
    end
    return 1'b1;
  endfunction

  function automatic sched_result_t schedule_decision(input sched_cmd_t c);
    sched_result_t r;
    int n;
    int total;
    int tk;
    int lo;
    int hi;
    int mid;
    r = '0;
    n = active_clients();
    case (c.command)
      CMD_WRITE_PRIO: begin
        prio_tbl[c.client_index] = c.priority_value;
      end
      CMD_REBUILD: begin
        if (rebuild_tickets()) r.rebuilt = 1'b1;
        else r.status = 1'b1;
      end
      CMD_DRAW: begin
        total = int'(cum_tbl[n-1]);
        if (total == 0) begin
          r.status = 1'b1;
        end else begin
          tk = 1 + ((total * int'(c.random_value)) >> 16);
          lo = 0;
          hi = n - 1;
          while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (int'(cum_tbl[mid]) >= tk) hi = mid;
            else lo = mid + 1;
          end
          r.winner       = lo[WIN_W-1:0];
          r.drawn_ticket = tk[TKT_W-1:0];
        end
      end
      default: begin
        tuple_acc = tuple_acc + ACC_W'(c.tuple_count);
        if (tuple_acc >= ACC_W'(cfg_cycle)) begin
          tuple_acc = '0;
          if (rebuild_tickets()) r.rebuilt = 1'b1;
          else r.status = 1'b1;
        end
      end
    endcase
    r.total_tickets = cum_tbl[n-1];
    return r;
  endfunction

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_word16();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    if (r < 4) return 16'($urandom_range(1, 255));
    return 16'($urandom());
  endfunction

  task automatic issue(input sched_cmd_t c, input bit typed, input sched_result_t given);
    sched_result_t predicted;
    int g;
    g = gap_cycles();
    repeat (g) begin
      @(negedge clk_i);
      cmd_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    cmd_if.valid          <= 1'b1;
    cmd_if.command        <= c.command;
    cmd_if.client_index   <= c.client_index;
    cmd_if.priority_value <= c.priority_value;
    cmd_if.random_value   <= c.random_value;
    cmd_if.tuple_count    <= c.tuple_count;
    do @(posedge clk_i); while (!cmd_if.ready);
    predicted = schedule_decision(c);
    awaited_results.push_back(typed ? given : predicted);
    sent_count++;
  endtask

  task automatic wait_results();
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
  endtask

  task automatic apply_settings(input logic [CNT_W-1:0] clients, input logic [CYC_W-1:0] cyc);
    logic [CFG_DATA_W-CNT_W-1:0] pad;
    pad = (CFG_DATA_W - CNT_W)'($urandom());
    wait_results();
    write_reg(CFG_CLIENT_COUNT, {pad, clients});
    write_reg(CFG_REBUILD_PERIOD, cyc);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    cfg_clients = clients;
    cfg_cycle   = cyc;
    settings_count++;
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("lottery_ticket_scheduler_tb: errors");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (awaited_results.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        oldest = awaited_results.pop_front();
        if (res_if.status !== oldest.status) begin
          $error("status expected %0d got %0d", oldest.status, res_if.status);
          errors++;
        end
        if (res_if.winner !== oldest.winner) begin
          $error("winner expected %0d got %0d", oldest.winner, res_if.winner);
          errors++;
        end
        if (res_if.drawn_ticket !== oldest.drawn_ticket) begin
          $error("drawn_ticket expected %0d got %0d", oldest.drawn_ticket,
                 res_if.drawn_ticket);
          errors++;
        end
        if (res_if.rebuilt !== oldest.rebuilt) begin
          $error("rebuilt expected %0d got %0d", oldest.rebuilt, res_if.rebuilt);
          errors++;
        end
        if (res_if.total_tickets !== oldest.total_tickets) begin
          $error("total_tickets expected %0d got %0d", oldest.total_tickets,
                 res_if.total_tickets);
          errors++;
        end
      end
      if (res_if.drawn_ticket != '0) won_draws++;
      if (res_if.rebuilt) rebuild_results++;
    end
  end

  // result side backpressure
  initial begin
    int hold;
    int g;
    bit level;
    res_if.ready = 1'b0;
    hold  = 0;
    level = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        hold--;
      end else if (!level || calm) begin
        level = 1'b1;
        hold  = $urandom_range(0, 15);
      end else begin
        g = gap_cycles();
        if (g == 0) begin
          level = 1'b1;
          hold  = $urandom_range(0, 15);
        end else begin
          level = 1'b0;
          hold  = g - 1;
        end
      end
      res_if.ready <= level;
    end
  end

  initial begin
    sched_cmd_t c;
    int n;
    int w;
    int span;
    int done;
    logic [CNT_W-1:0] clients;
    logic [CYC_W-1:0] cyc;

    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = CFG_CLIENT_COUNT;
    cfg_data              = '0;
    cmd_if.valid          = 1'b0;
    cmd_if.command        = CMD_WRITE_PRIO;
    cmd_if.client_index   = '0;
    cmd_if.priority_value = '0;
    cmd_if.random_value   = '0;
    cmd_if.tuple_count    = '0;
    errors          = 0;
    cycle_count     = 0;
    sent_count      = 0;
    settings_count  = 0;
    won_draws       = 0;
    rebuild_results = 0;
    calm            = 1'b0;
    for (int i = 0; i < CLIENTS; i++) begin
      prio_tbl[i] = '0;
      cum_tbl[i]  = '0;
    end
    tuple_acc   = '0;
    cfg_clients = CLIENT_COUNT_RESET;
    cfg_cycle   = REBUILD_PERIOD_RESET;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED[r].set_cfg) apply_settings(DIRECTED[r].clients, DIRECTED[r].cycle_len);
      issue(DIRECTED[r].cmd, DIRECTED[r].typed, DIRECTED[r].res);
    end

    // random phases
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin clients = 5'd16; cyc = 16'd1;     end
        1:       begin clients = 5'd1;  cyc = 16'hFFFF;  end
        2:       begin clients = 5'd0;  cyc = 16'd0;     end
        3:       begin clients = 5'd31; cyc = 16'd50;    end
        default: begin
          if ($urandom_range(0, 3) == 0) clients = 5'($urandom_range(0, 31));
          else clients = 5'($urandom_range(2, 16));
          w = $urandom_range(0, 3);
          if (w == 0) cyc = 16'($urandom_range(0, 3));
          else if (w == 1) cyc = 16'($urandom());
          else cyc = 16'($urandom_range(1, 400));
        end
      endcase
      apply_settings(clients, cyc);
      calm = (p == 5) || ($urandom_range(0, 4) == 0);
      n    = active_clients();
      done = 0;

      // usual case: load every active client, then rebuild
      if ($urandom_range(0, 4) != 0) begin
        for (int i = 0; i < n; i++) begin
          c = '{CMD_WRITE_PRIO, 4'(i), pick_word16(), 16'($urandom()), 16'($urandom())};
          issue(c, 1'b0, '0);
          done++;
        end
        c = '{CMD_REBUILD, 4'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom())};
        issue(c, 1'b0, '0);
        done++;
      end

      while (done < ITEMS_PER_PHASE) begin
        c.client_index   = 4'($urandom_range(0, 15));
        c.priority_value = pick_word16();
        c.random_value   = pick_word16();
        w = $urandom_range(0, 9);
        span = (int'(cfg_cycle) > 30000) ? 65535 : 2 * int'(cfg_cycle) + 4;
        if (w == 0) c.tuple_count = 16'h0000;
        else if (w == 1) c.tuple_count = 16'hFFFF;
        else if (w < 4) c.tuple_count = 16'($urandom());
        else c.tuple_count = 16'($urandom_range(0, span));
        w = $urandom_range(0, 99);
        if (w < 25) begin
          c.command = CMD_WRITE_PRIO;
          if ($urandom_range(0, 3) != 0) c.client_index = 4'($urandom_range(0, n - 1));
        end else if (w < 35) begin
          c.command = CMD_REBUILD;
        end else if (w < 80) begin
          c.command = CMD_DRAW;
        end else begin
          c.command = CMD_REPORT;
        end
        issue(c, 1'b0, '0);
        done++;
        if ($urandom_range(0, 49) == 0) wait_results();
      end
    end

    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d command transactions over %0d register settings", sent_count,
             settings_count);
    $display("%0d winning draws and %0d table rebuilds seen", won_draws, rebuild_results);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("lottery_ticket_scheduler_tb: clean");
    end else begin
      $display("lottery_ticket_scheduler_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
